/* hw/rtl/iptc_pkg.sv */
// Shared types, constants and lookup functions for the infix-to-postfix converter.
// Depends on nothing; every other file of the block but iptc_if imports it.
package iptc_pkg;

	// Operator stack geometry (the top entry lives in a register, the rest in an array)
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SA_DEPTH    = STACK_DEPTH - 1;
	localparam int SA_W        = (SA_DEPTH > 1) ? $clog2(SA_DEPTH) : 1;

	// Characters of interest
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ERR   = 8'h45;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	// Operator codes as held on the stack
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;
	localparam logic [2:0] OP_LPAR = 3'd5;

	// Precedence classes
	localparam logic [2:0] CLS_ADD  = 3'd0;
	localparam logic [2:0] CLS_MUL  = 3'd1;
	localparam logic [2:0] CLS_POW  = 3'd2;
	localparam logic [2:0] CLS_LPAR = 3'd3;
	localparam logic [2:0] CLS_RPAR = 3'd4;
	localparam logic [2:0] CLS_END  = 3'd5;

	// Stack actions
	localparam logic [1:0] ACT_POP   = 2'd0;
	localparam logic [1:0] ACT_PUSH  = 2'd1;
	localparam logic [1:0] ACT_MATCH = 2'd2;
	localparam logic [1:0] ACT_ERR   = 2'd3;

	// Token kinds from the classifier
	localparam logic [1:0] KIND_LETTER = 2'd0;
	localparam logic [1:0] KIND_BAD    = 2'd1;
	localparam logic [1:0] KIND_OP     = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] cls;
		logic [2:0] code;
		logic [7:0] ch;
	} iptc_tok_t;

	// Class of a stacked operator code
	function automatic logic [2:0] code_class(logic [2:0] code);
		logic [2:0] c;
		c = CLS_LPAR;
		unique case (code)
			OP_ADD, OP_SUB: c = CLS_ADD;
			OP_MUL, OP_DIV: c = CLS_MUL;
			OP_POW:         c = CLS_POW;
			default:        c = CLS_LPAR;
		endcase
		return c;
	endfunction

	// Character emitted for a popped operator code
	function automatic logic [7:0] code_char(logic [2:0] code);
		logic [7:0] c;
		c = CH_ERR;
		unique case (code)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			OP_POW:  c = CH_CARET;
			OP_LPAR: c = CH_LPAR;
			default: c = CH_ERR;
		endcase
		return c;
	endfunction

	// Precedence table: incoming class against top-of-stack class
	function automatic logic [1:0] prec_act(logic [2:0] cls, logic [2:0] top);
		logic [1:0] a;
		a = ACT_ERR;
		unique case (cls)
			CLS_ADD: begin
				if (top == CLS_LPAR || top == CLS_END) a = ACT_PUSH;
				else if (top == CLS_RPAR) a = ACT_ERR;
				else a = ACT_POP;
			end
			CLS_MUL: begin
				if (top == CLS_MUL || top == CLS_POW) a = ACT_POP;
				else if (top == CLS_RPAR) a = ACT_ERR;
				else a = ACT_PUSH;
			end
			CLS_POW, CLS_LPAR: begin
				if (top == CLS_RPAR) a = ACT_ERR;
				else a = ACT_PUSH;
			end
			CLS_RPAR: begin
				if (top == CLS_LPAR) a = ACT_MATCH;
				else if (top == CLS_RPAR || top == CLS_END) a = ACT_ERR;
				else a = ACT_POP;
			end
			CLS_END: begin
				if (top == CLS_END) a = ACT_MATCH;
				else if (top == CLS_LPAR || top == CLS_RPAR) a = ACT_ERR;
				else a = ACT_POP;
			end
			default: a = ACT_ERR;
		endcase
		return a;
	endfunction

endpackage

/* hw/rtl/iptc_if.sv */
// Valid/ready channel interfaces for the infix-to-postfix converter.
// Standalone; no package needed.
interface iptc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface iptc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       is_error;
	logic       expr_end;
	logic       last;

	modport source (output valid, output out_char, output is_error, output expr_end,
		output last, input ready);
	modport sink   (input valid, input out_char, input is_error, input expr_end,
		input last, output ready);
endinterface

/* hw/rtl/iptc_front.sv */
// Front end: accepts input words and classifies each character into a token.
// Depends on iptc_pkg and iptc_in_if.
module iptc_front (
	input  logic                clk,
	input  logic                arst_n,
	iptc_in_if.sink             infix,
	output iptc_pkg::iptc_tok_t tok,
	output logic                tok_valid,
	input  logic                tok_ready
);
	import iptc_pkg::*;

	iptc_tok_t tok_d;
	iptc_tok_t tok_s1;
	logic      valid_s1;

	// Classify the incoming character
	always_comb begin
		tok_d.kind = KIND_OP;
		tok_d.cls  = CLS_END;
		tok_d.code = OP_ADD;
		tok_d.ch   = infix.in_char;
		priority if ((infix.in_char >= CH_LA && infix.in_char <= CH_LZ) ||
			(infix.in_char >= CH_UA && infix.in_char <= CH_UZ)) begin
			tok_d.kind = KIND_LETTER;
		end else begin
			unique case (infix.in_char)
				CH_PLUS:  begin tok_d.cls = CLS_ADD;  tok_d.code = OP_ADD;  end
				CH_MINUS: begin tok_d.cls = CLS_ADD;  tok_d.code = OP_SUB;  end
				CH_STAR:  begin tok_d.cls = CLS_MUL;  tok_d.code = OP_MUL;  end
				CH_SLASH: begin tok_d.cls = CLS_MUL;  tok_d.code = OP_DIV;  end
				CH_CARET: begin tok_d.cls = CLS_POW;  tok_d.code = OP_POW;  end
				CH_LPAR:  begin tok_d.cls = CLS_LPAR; tok_d.code = OP_LPAR; end
				CH_RPAR:  tok_d.cls = CLS_RPAR;
				CH_HASH:  tok_d.cls = CLS_END;
				default:  tok_d.kind = KIND_BAD;
			endcase
		end
	end

	assign infix.ready = !valid_s1 || tok_ready;
	assign tok         = tok_s1;
	assign tok_valid   = valid_s1;

	// Hold the classified token until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (infix.ready) begin
			valid_s1 <= infix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (infix.ready && infix.valid) begin
			tok_s1 <= tok_d;
		end
	end

endmodule

/* hw/rtl/iptc_queue.sv */
// Two-entry token queue between the classifier and the stack engine.
// Depends on iptc_pkg.
module iptc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  iptc_pkg::iptc_tok_t wr_tok,
	input  logic                wr_valid,
	output logic                wr_ready,
	output iptc_pkg::iptc_tok_t rd_tok,
	output logic                rd_valid,
	input  logic                rd_ready
);
	import iptc_pkg::*;

	iptc_tok_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_tok   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) fill_q <= fill_q + 2'd1;
			else if (do_rd && !do_wr) fill_q <= fill_q - 2'd1;
		end
	end

	// Store tokens
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

/* hw/rtl/iptc_back.sv */
// Back end: operator stack engine, one stack step per cycle while the output is not stalled, with output register.
// Depends on iptc_pkg and iptc_out_if.
module iptc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  iptc_pkg::iptc_tok_t tok,
	input  logic                tok_valid,
	output logic                tok_ready,
	iptc_out_if.source          postfix
);
	import iptc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       top_q;
	logic [2:0]       stk_q [SA_DEPTH];

	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_err_q;
	logic             out_end_q;
	logic             out_last_q;

	logic             slot_free;
	logic             step;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_m2;
	logic [2:0]       below;
	logic [2:0]       top_cls;
	logic [2:0]       next_cls;
	logic [1:0]       act;
	logic [1:0]       nact;
	logic             next_emits;
	logic             full;

	logic             emit;
	logic [7:0]       e_char;
	logic             e_err;
	logic             e_end;
	logic             e_last;
	logic             done;
	logic             do_push;
	logic             do_pop;
	logic             do_clear;

	assign slot_free = !out_valid_q || postfix.ready;
	assign step      = tok_valid && slot_free;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign cnt_m2    = cnt_q - CNT_W'(2);
	assign below     = stk_q[cnt_m2[SA_W-1:0]];
	assign full      = (cnt_q == CNT_W'(STACK_DEPTH));

	// Look up the action for the current top and for the entry below it
	assign top_cls    = (cnt_q == '0) ? CLS_END : code_class(top_q);
	assign next_cls   = (cnt_q >= CNT_W'(2)) ? code_class(below) : CLS_END;
	assign act        = prec_act(tok.cls, top_cls);
	assign nact       = prec_act(tok.cls, next_cls);
	assign next_emits = (nact == ACT_POP) || (nact == ACT_ERR) ||
		((nact == ACT_MATCH) && (tok.cls == CLS_END));

	// Decide this step: what to emit and how the stack moves
	always_comb begin
		emit     = 1'b0;
		e_char   = CH_ERR;
		e_err    = 1'b0;
		e_end    = 1'b0;
		e_last   = 1'b1;
		done     = 1'b1;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		unique case (tok.kind)
			KIND_LETTER: begin
				emit   = 1'b1;
				e_char = tok.ch;
			end
			KIND_BAD: begin
				emit  = 1'b1;
				e_err = 1'b1;
			end
			KIND_OP: begin
				unique case (act)
					ACT_PUSH: begin
						if (full) begin
							emit  = 1'b1;
							e_err = 1'b1;
						end else begin
							do_push = 1'b1;
						end
					end
					ACT_POP: begin
						emit   = 1'b1;
						e_char = code_char(top_q);
						e_last = !next_emits;
						done   = 1'b0;
						do_pop = 1'b1;
					end
					ACT_MATCH: begin
						if (tok.cls == CLS_END) begin
							emit     = 1'b1;
							e_char   = CH_NL;
							e_end    = 1'b1;
							do_clear = 1'b1;
						end else begin
							do_pop = 1'b1;
						end
					end
					default: begin
						emit  = 1'b1;
						e_err = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign tok_ready = step && done;

	// Advance the stack depth and top-of-stack register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step) begin
			if (do_push) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop) cnt_q <= cnt_m1;
			else if (do_clear) cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && do_push) begin
			top_q <= tok.code;
		end else if (step && do_pop) begin
			top_q <= below;
		end
	end

	// Spill the old top into the array on a push
	always_ff @(posedge clk) begin
		if (step && do_push && cnt_q != '0) begin
			stk_q[cnt_m1[SA_W-1:0]] <= top_q;
		end
	end

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_char_q <= e_char;
			out_err_q  <= e_err;
			out_end_q  <= e_end;
			out_last_q <= e_last;
		end
	end

	assign postfix.valid    = out_valid_q;
	assign postfix.out_char = out_char_q;
	assign postfix.is_error = out_err_q;
	assign postfix.expr_end = out_end_q;
	assign postfix.last     = out_last_q;

endmodule

/* hw/rtl/infix_to_postfix_converter.sv */
// Infix-to-postfix converter: classifier, token queue and operator stack engine.
// Path: classifier register, token queue entry, then the output register.
// Throughput: one stack step per cycle while a token waits and the output is not stalled;
// a character's earlier steps each pop an operator, its final step emits, pushes or cancels.
// Reset: arst_n clears the stack depth, the queue and all valid flags.
module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	iptc_in_if.sink    infix,
	iptc_out_if.source postfix
);
	import iptc_pkg::*;

	iptc_tok_t front_tok;
	logic      front_valid;
	logic      front_ready;
	iptc_tok_t back_tok;
	logic      back_valid;
	logic      back_ready;

	// Classify incoming characters
	iptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.infix     (infix),
		.tok       (front_tok),
		.tok_valid (front_valid),
		.tok_ready (front_ready)
	);

	// Decouple classifier from stack engine
	iptc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_tok   (front_tok),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_tok   (back_tok),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// Run the operator stack and emit postfix words
	iptc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (back_tok),
		.tok_valid (back_valid),
		.tok_ready (back_ready),
		.postfix   (postfix)
	);

endmodule
